FILE: src/acfd_pkg.sv
// Shared constants, types and command table lookup for the ASCII command frame decoder.
`timescale 1ns / 1ps
package acfd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORD_W   = 16;
    localparam int unsigned POS_W    = 4;
    localparam int unsigned ENTRY_W  = 4;
    localparam int unsigned TABLE_N  = 15;
    localparam int unsigned OUT_W    = 40;

    localparam logic [POS_W-1:0]  POS_HUNT   = 4'd0;
    localparam logic [POS_W-1:0]  POS_CMD_HI = 4'd3;
    localparam logic [POS_W-1:0]  POS_SIGN   = 4'd5;
    localparam logic [POS_W-1:0]  POS_VAL_LO = 4'd6;
    localparam logic [POS_W-1:0]  POS_VAL_HI = 4'd10;
    localparam logic [POS_W-1:0]  POS_LAST   = 4'd11;

    localparam logic [BYTE_W-1:0] CH_START = 8'd64;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'd45;
    localparam logic [WORD_W-1:0] CH_ZERO  = 16'd48;

    localparam logic [WORD_W-1:0] CMD_TABLE [TABLE_N] = '{
        16'd0, 16'd1, 16'd2, 16'd3, 16'd4,
        16'd100, 16'd101, 16'd102, 16'd103, 16'd104,
        16'd105, 16'd106, 16'd107, 16'd108, 16'd109
    };

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] command;
        logic [WORD_W-1:0] value_mag;
        logic              negative;
    } t_frame;

    typedef struct packed {
        logic               matched;
        logic [ENTRY_W-1:0] entry;
    } t_match;

    function automatic t_match lookup_cmd(input logic [WORD_W-1:0] cmd);
        t_match m;
        m = '0;
        for (int i = TABLE_N - 1; i >= 0; i--) begin
            if (CMD_TABLE[i] == cmd) begin
                m.matched = 1'b1;
                m.entry   = ENTRY_W'(i);
            end
        end
        return m;
    endfunction

    function automatic logic [WORD_W-1:0] times_ten(input logic [WORD_W-1:0] a);
        return WORD_W'({a[WORD_W-4:0], 3'b000}) + WORD_W'({a[WORD_W-2:0], 1'b0});
    endfunction

endpackage

FILE: src/acfd_parser.sv
// Frame position tracking and digit accumulation for incoming bytes.
`timescale 1ns / 1ps
module acfd_parser (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_link_enabled,
    input  logic                         i_valid,
    input  logic [acfd_pkg::BYTE_W-1:0]  i_byte,
    input  logic                         i_out_busy,
    output logic                         o_ready,
    output acfd_pkg::t_frame             o_frame
);
    import acfd_pkg::*;

    logic [POS_W-1:0]  r_pos, n_pos;
    logic [WORD_W-1:0] r_cmd, n_cmd;
    logic [WORD_W-1:0] r_val, n_val;
    logic              r_neg, n_neg;
    logic [WORD_W-1:0] digit;
    logic              take;

    assign o_ready = !(i_out_busy && r_pos == POS_LAST);
    assign take    = i_valid && o_ready && i_link_enabled;
    assign digit   = WORD_W'(i_byte) - CH_ZERO;

    always_comb begin
        n_pos = r_pos;
        n_cmd = r_cmd;
        n_val = r_val;
        n_neg = r_neg;
        o_frame.valid     = 1'b0;
        o_frame.command   = r_cmd;
        o_frame.value_mag = r_val;
        o_frame.negative  = r_neg;
        if (take) begin
            if (r_pos == POS_HUNT) begin
                if (i_byte == CH_START) begin
                    n_pos = POS_HUNT + POS_W'(1);
                    n_cmd = '0;
                    n_val = '0;
                    n_neg = 1'b0;
                end
            end else if (r_pos > POS_LAST) begin
                n_pos = POS_HUNT;
            end else begin
                if (r_pos <= POS_CMD_HI) begin
                    n_cmd = times_ten(r_cmd) + digit;
                end else if (r_pos == POS_SIGN) begin
                    n_neg = (i_byte == CH_MINUS);
                end else if (r_pos >= POS_VAL_LO && r_pos <= POS_VAL_HI) begin
                    n_val = times_ten(r_val) + digit;
                end
                if (r_pos < POS_LAST) begin
                    n_pos = r_pos + POS_W'(1);
                end else begin
                    n_pos = POS_HUNT;
                    o_frame.valid = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_HUNT;
            r_cmd <= '0;
            r_val <= '0;
            r_neg <= 1'b0;
        end else begin
            r_pos <= n_pos;
            r_cmd <= n_cmd;
            r_val <= n_val;
            r_neg <= n_neg;
        end
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_LAST)
        else $error("frame position beyond last byte");
    a_frame_at_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame.valid |=> r_pos == POS_HUNT)
        else $error("frame end did not return to hunting");
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_pos == POS_HUNT && i_byte == CH_START) |=> (r_cmd == '0 && !r_neg))
        else $error("start byte did not clear accumulators");

endmodule

FILE: src/acfd_result.sv
// Sign application, command table match and output register.
`timescale 1ns / 1ps
module acfd_result (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  acfd_pkg::t_frame             i_frame,
    input  logic                         i_ready,
    output logic                         o_valid,
    output logic [acfd_pkg::OUT_W-1:0]   o_data,
    output logic                         o_busy
);
    import acfd_pkg::*;

    logic                r_valid, n_valid;
    logic [WORD_W-1:0]   r_cmd;
    logic [WORD_W-1:0]   r_val;
    t_match              r_match;
    t_match              match;
    logic [WORD_W-1:0]   signed_val;

    assign match      = lookup_cmd(i_frame.command);
    assign signed_val = i_frame.negative ? WORD_W'(16'd0 - i_frame.value_mag)
                                         : i_frame.value_mag;
    assign n_valid    = i_frame.valid || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_frame.valid) begin
            r_cmd   <= i_frame.command;
            r_val   <= signed_val;
            r_match <= match;
        end
    end

    assign o_valid = r_valid;
    assign o_busy  = r_valid;
    assign o_data  = {3'b000, r_match.entry, r_match.matched, r_val, r_cmd};

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_frame.valid |-> !r_valid)
        else $error("new frame while result still held");
    a_unmatched_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_match.matched) |-> r_match.entry == '0)
        else $error("entry set without a match");
    a_match_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_match.matched) |->
            (CMD_TABLE[r_match.entry] == r_cmd && r_match.entry < ENTRY_W'(TABLE_N)))
        else $error("match entry does not hold the command");

endmodule

FILE: src/ascii_command_frame_decoder.sv
// Top level of the ASCII command frame decoder.
`timescale 1ns / 1ps
// Usage:
//   Slave stream s_axis_* carries one received byte per beat. While the link
//   enable register is 0 beats are accepted, but for the stall below, and dropped.
//   While it is 1 the block hunts for '@', then collects the next 11 bytes: three
//   command digits, an ignored byte, a sign byte, five value digits and an ignored byte.
//   Master stream m_axis_* carries one result beat per frame: command, signed
//   value, a table-match flag and the first matching table entry.
//   cfg_* writes the link enable bit; cfg_ready is always high.
//   Throughput: one byte per cycle. The only stall is at the final byte of a
//   frame while the previous result beat is still held in the output register.
//   Latency: the result beat is valid the cycle after the final byte is taken.
//   Reset clears the link enable, the frame position and the output valid.
//   A stalled receiver holds the result; byte intake continues until the next
//   frame reaches its final byte.
module ascii_command_frame_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_data,       // link_enabled
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [acfd_pkg::BYTE_W-1:0]   s_axis_tdata,     // rx_byte
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [acfd_pkg::OUT_W-1:0]    m_axis_tdata      // command, value, matched, entry, pad
);
    import acfd_pkg::*;

    logic   r_link_en;
    logic   out_busy;
    t_frame frame;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_en <= 1'b0;
        end else if (i_cfg_valid) begin
            r_link_en <= i_cfg_data;
        end
    end

    acfd_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_link_enabled (r_link_en),
        .i_valid        (s_axis_tvalid),
        .i_byte         (s_axis_tdata),
        .i_out_busy     (out_busy),
        .o_ready        (s_axis_tready),
        .o_frame        (frame)
    );

    acfd_result u_result (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_frame (frame),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (m_axis_tdata),
        .o_busy  (out_busy)
    );

endmodule
